// ----- hw/rtl/directory_multicast_fanout_core_assert.svh -----
// assertion macros shared by the fan-out checks
`ifndef DIRECTORY_MULTICAST_FANOUT_CORE_ASSERT_SVH
`define DIRECTORY_MULTICAST_FANOUT_CORE_ASSERT_SVH

// same-cycle implication
`define DMF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fan-out port check failed");

// next-cycle implication
`define DMF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fan-out port check failed");

`endif

// ----- hw/rtl/dmf_pkg.sv -----
package dmf_pkg;

   // field widths
   localparam int NODE_W = 6;
   localparam int MASK_W = 17;
   localparam int SCAN_N = 32;
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 5;

   // commands
   localparam logic [1:0] CMD_REQ = 2'd0;
   localparam logic [1:0] CMD_P2P = 2'd1;
   localparam logic [1:0] CMD_ACK = 2'd2;

   // message types that fan out
   localparam logic [2:0] MT_READ    = 3'd1;
   localparam logic [2:0] MT_READ_EX = 3'd2;

   // register indexes
   localparam logic [1:0] CSR_NUMA      = 2'd0;
   localparam logic [1:0] CSR_UNIDIR    = 2'd1;
   localparam logic [1:0] CSR_PROCS     = 2'd2;
   localparam logic [1:0] CSR_PTR_LIMIT = 2'd3;

   // register reset values
   localparam logic [4:0] PROC_COUNT_RST = 5'd16;
   localparam logic [4:0] PTR_LIMIT_RST  = 5'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_FAN,
      ST_ACK_MEM
   } state_type;

endpackage

// ----- hw/rtl/directory_multicast_fanout_core.sv -----
// start is taken only while idle; ST_HEAD sets up the first copy, which is registered into the copy outputs
// a fan-out request sends its memory copy, then scans the nodes in order up to the highest selected one,
// one node scanned per cycle; the next request is taken only after the sequencer returns to idle
// a forward sends a single copy, an ack copied to memory sends a second one; the receiver cannot stall
// copies come at most one per cycle, with a gap for each scanned node that gets none
// synchronous reset clears the sequencer and loads the register defaults
module directory_multicast_fanout_core #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_msg_type,
   input  logic [4:0]  req_sender_id,
   input  logic        req_sender_is_memory,
   input  logic [4:0]  req_receiver_id,
   input  logic [47:0] req_address,
   input  logic [7:0]  req_flag_bits,
   input  logic        req_transmit_to_memory,
   input  logic [16:0] req_sharer_mask,
   input  logic [3:0]  req_home_node,
   output logic        rsp_valid,
   output logic [2:0]  rsp_out_msg_type,
   output logic [4:0]  rsp_out_sender,
   output logic [4:0]  rsp_out_receiver,
   output logic [8:0]  rsp_link_index,
   output logic [47:0] rsp_out_address,
   output logic [7:0]  rsp_out_flags,
   output logic        rsp_last_result,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int NW = dmf_pkg::NODE_W;
   localparam int SN = dmf_pkg::SCAN_N;
   localparam logic [5:0] MaxProcs = 6'(MAX_PROCS);

   // configuration registers
   logic       numa_ff;
   logic       unidir_ff;
   logic [4:0] procs_ff;
   logic [4:0] plimit_ff;

   // latched input word
   logic [1:0]  cmd_ff;
   logic [2:0]  type_ff;
   logic [4:0]  sender_ff;
   logic        from_mem_ff;
   logic [4:0]  recv_ff;
   logic [47:0] addr_ff;
   logic [7:0]  flags_ff;
   logic        xmit_ff;
   logic [dmf_pkg::MASK_W-1:0] mask_ff;
   logic [3:0]  home_ff;

   // sequencer
   dmf_pkg::state_type state_ff, state_in;
   logic [SN-1:0]              rem_ff, rem_in;
   logic [dmf_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       accept;

   // copy output registers
   logic        rsp_valid_ff;
   logic [4:0]  rsp_sender_ff;
   logic [4:0]  rsp_receiver_ff;
   logic [8:0]  rsp_link_ff;
   logic        rsp_last_ff;
   logic [2:0]  rsp_type_ff;
   logic [47:0] rsp_addr_ff;
   logic [7:0]  rsp_flags_ff;

   // derived node numbers
   logic [4:0]    n_sat;
   logic [NW-1:0] n_plus1;
   logic [NW-1:0] mem_node;
   logic [NW-1:0] sender_eff;
   logic [SN-1:0] scan_vec;
   logic [SN-1:0] mask_wide;
   logic [SN-1:0] sel;
   logic [dmf_pkg::CNT_W-1:0] sharer_cnt;
   logic          fan_all;
   logic          is_fanout;

   // step outputs
   logic          emit;
   logic          emit_last;
   logic [NW-1:0] tgt;
   logic [SN-1:0] bit_sel;
   logic [SN-1:0] rem_clr;

   // shared link unit
   logic [NW-1:0] s_eff, r_eff, lnk_a, lnk_b;
   logic [11:0]   lnk_sum;

   assign accept = start && (state_ff == dmf_pkg::ST_IDLE);
   assign busy   = (state_ff != dmf_pkg::ST_IDLE);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         numa_ff   <= 1'b0;
         unidir_ff <= 1'b0;
         procs_ff  <= dmf_pkg::PROC_COUNT_RST;
         plimit_ff <= dmf_pkg::PTR_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            dmf_pkg::CSR_NUMA:      numa_ff   <= csr_wdata[0];
            dmf_pkg::CSR_UNIDIR:    unidir_ff <= csr_wdata[0];
            dmf_pkg::CSR_PROCS:     procs_ff  <= csr_wdata;
            dmf_pkg::CSR_PTR_LIMIT: plimit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_command;
         type_ff     <= req_msg_type;
         sender_ff   <= req_sender_id;
         from_mem_ff <= req_sender_is_memory;
         recv_ff     <= req_receiver_id;
         addr_ff     <= req_address;
         flags_ff    <= req_flag_bits;
         xmit_ff     <= req_transmit_to_memory;
         mask_ff     <= req_sharer_mask;
         home_ff     <= req_home_node;
      end
   end

   // node numbering under the current configuration
   always_comb begin
      n_sat      = ({1'b0, procs_ff} > MaxProcs) ? MaxProcs[4:0] : procs_ff;
      n_plus1    = {1'b0, n_sat} + 6'd1;
      mem_node   = numa_ff ? n_plus1 : {1'b0, n_sat};
      sender_eff = from_mem_ff ? mem_node : {1'b0, sender_ff};
      mask_wide  = {{(SN - dmf_pkg::MASK_W){1'b0}}, mask_ff};
      for (int i = 0; i < SN; i++) begin
         scan_vec[i] = (NW'(i) < mem_node);
      end
      sharer_cnt = dmf_pkg::CNT_W'($countones(mask_ff & scan_vec[dmf_pkg::MASK_W-1:0]));
      fan_all    = (sharer_cnt > plimit_ff);
      for (int i = 0; i < SN; i++) begin
         sel[i] = scan_vec[i] && (fan_all || mask_wide[i]) && (NW'(i) != sender_eff);
      end
      is_fanout = (cmd_ff != dmf_pkg::CMD_ACK)
                  && ((type_ff == dmf_pkg::MT_READ) || (type_ff == dmf_pkg::MT_READ_EX));
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   // next state and per-step copy selection
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      emit_last = 1'b0;
      tgt       = mem_node;
      bit_sel   = {{(SN - 1){1'b0}}, 1'b1} << idx_ff;
      rem_clr   = rem_ff & ~bit_sel;
      case (state_ff)
         dmf_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dmf_pkg::ST_HEAD;
            end
         end
         dmf_pkg::ST_HEAD: begin
            emit = 1'b1;
            if (is_fanout) begin
               tgt       = mem_node;
               emit_last = (sel == '0);
               rem_in    = sel;
               idx_in    = '0;
               state_in  = emit_last ? dmf_pkg::ST_IDLE : dmf_pkg::ST_FAN;
            end else begin
               tgt       = {1'b0, recv_ff};
               emit_last = !((cmd_ff == dmf_pkg::CMD_ACK) && xmit_ff);
               state_in  = emit_last ? dmf_pkg::ST_IDLE : dmf_pkg::ST_ACK_MEM;
            end
         end
         dmf_pkg::ST_FAN: begin
            // one scanned node per cycle
            tgt       = {1'b0, idx_ff};
            emit      = rem_ff[idx_ff];
            emit_last = (rem_clr == '0);
            idx_in    = idx_ff + dmf_pkg::IDX_W'(1);
            if (emit) begin
               rem_in = rem_clr;
               if (emit_last) begin
                  state_in = dmf_pkg::ST_IDLE;
               end
            end
         end
         dmf_pkg::ST_ACK_MEM: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            tgt       = mem_node;
            state_in  = dmf_pkg::ST_IDLE;
         end
         default: begin
            state_in = dmf_pkg::ST_IDLE;
         end
      endcase
   end

   // shared link unit: a * (n + 1) + b
   always_comb begin
      s_eff   = (numa_ff && (sender_eff == n_plus1)) ? {2'b00, home_ff} : sender_eff;
      r_eff   = (numa_ff && (tgt == n_plus1)) ? {2'b00, home_ff} : tgt;
      lnk_a   = (unidir_ff || (s_eff < r_eff)) ? s_eff : r_eff;
      lnk_b   = (unidir_ff || (s_eff < r_eff)) ? r_eff : s_eff;
      lnk_sum = (12'(lnk_a) * 12'(n_plus1)) + {6'd0, lnk_b};
   end

   // copy strobe and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sender_ff   <= sender_eff[4:0];
         rsp_receiver_ff <= tgt[4:0];
         rsp_link_ff     <= lnk_sum[8:0];
         rsp_last_ff     <= emit_last;
         rsp_type_ff     <= type_ff;
         rsp_addr_ff     <= addr_ff;
         rsp_flags_ff    <= flags_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_msg_type = rsp_type_ff;
   assign rsp_out_sender   = rsp_sender_ff;
   assign rsp_out_receiver = rsp_receiver_ff;
   assign rsp_link_index   = rsp_link_ff;
   assign rsp_out_address  = rsp_addr_ff;
   assign rsp_out_flags    = rsp_flags_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

// ----- hw/rtl/dmf_checker.sv -----
`include "directory_multicast_fanout_core_assert.svh"

module dmf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_result
);

   // an accepted word occupies the sequencer
   `DMF_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)

   // no copy is strobed in the cycle after a word is taken
   `DMF_ASSERT_NXT(a_accept_quiet, clock, reset, start && !busy, !rsp_valid)

   // a copy seen while idle closes the previous word
   `DMF_ASSERT_IMP(a_idle_last, clock, reset, rsp_valid && !busy, rsp_last_result)

   // every copy comes from a busy cycle
   `DMF_ASSERT_IMP(a_copy_source, clock, reset, rsp_valid, $past(busy))

endmodule

bind directory_multicast_fanout_core dmf_checker u_dmf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_last_result (rsp_last_result)
);
